FILE: sv/sco_pkg.sv
// Shared types, constants and helper functions for the solid column occlusion block.
package sco_pkg;

    localparam int COLUMNS    = 128;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int RANGE_W    = 8;
    localparam int OP_W       = 2;
    localparam int WORD_BITS  = 8;
    localparam int WORD_IDX_W = $clog2(WORD_BITS);
    localparam int ROWS       = COLUMNS / WORD_BITS;
    localparam int ROW_W      = $clog2(ROWS);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_CLIP  = 2'd1,
        OP_TEST  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             span_valid;
        logic [COL_W-1:0] span_start;
        logic [COL_W-1:0] span_end;
        logic             any_open;
        logic             last_result;
    } rsp_t;

    typedef struct packed {
        logic en;
        rsp_t item;
    } push_t;

    typedef struct packed {
        logic                 wr_en;
        logic [ROW_W-1:0]     wr_addr;
        logic [WORD_BITS-1:0] wr_data;
        logic                 rd_en;
        logic [ROW_W-1:0]     rd_addr;
    } mem_req_t;

    // Columns past the screen edge are pinned to the edge.
    function automatic logic [RANGE_W-1:0] clamp_col(input logic [RANGE_W-1:0] v);
        return (v > RANGE_W'(COLUMNS)) ? RANGE_W'(COLUMNS) : v;
    endfunction

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [WORD_IDX_W-1:0] first_one(input logic [WORD_BITS-1:0] v);
        logic [WORD_IDX_W-1:0] idx;
        idx = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                idx = WORD_IDX_W'(k);
            end
        end
        return idx;
    endfunction

    // Mask of the bit positions strictly below idx.
    function automatic logic [WORD_BITS-1:0] below_mask(input logic [WORD_IDX_W-1:0] idx);
        logic [WORD_BITS-1:0] m;
        for (int k = 0; k < WORD_BITS; k++)
        begin
            m[k] = (WORD_IDX_W'(k) < idx);
        end
        return m;
    endfunction

endpackage

FILE: sv/sco_if.sv
// Request and result channel interfaces with valid/ready handshake.
interface sco_req_if;
    logic                        valid;
    logic                        ready;
    logic [sco_pkg::OP_W-1:0]    operation;
    logic [sco_pkg::RANGE_W-1:0] first_col;
    logic [sco_pkg::RANGE_W-1:0] end_col;
    logic                        solid;

    modport source (output valid, output operation, output first_col, output end_col,
                    output solid, input ready);
    modport sink (input valid, input operation, input first_col, input end_col,
                  input solid, output ready);
endinterface

interface sco_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      span_valid;
    logic [sco_pkg::COL_W-1:0] span_start;
    logic [sco_pkg::COL_W-1:0] span_end;
    logic                      any_open;
    logic                      last_result;

    modport source (output valid, output span_valid, output span_start, output span_end,
                    output any_open, output last_result, input ready);
    modport sink (input valid, input span_valid, input span_start, input span_end,
                  input any_open, input last_result, output ready);
endinterface

FILE: sv/solid_column_occlusion.sv
// Clip takes the request, visits each row of the range in turn and ends with a final step.
// Test stops at the first row with an open column; clear, op 3 and empty ranges go straight to the final step.
// Each span waits in a pending slot for the next span or the final step; steps stall on a full output.
// A new request is taken only after the final result of the previous one enters the register.
// Reset clears the per-row valid bits at once, so every column reads open with no clearing pass.
// Top level of the column occlusion map: scan sequencer, row memory and result register.
module solid_column_occlusion (
    input  logic      clk,
    input  logic      rst_n,
    sco_req_if.sink   req,
    sco_rsp_if.source rsp
);
    import sco_pkg::*;

    push_t                push;
    mem_req_t             mem_req;
    logic                 out_free;
    logic [WORD_BITS-1:0] rd_data;

    sco_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .push     (push),
        .mem_req  (mem_req),
        .rd_data  (rd_data)
    );

    sco_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROWS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    sco_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .out_free (out_free),
        .rsp      (rsp)
    );

endmodule

FILE: sv/sco_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sco_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/sco_out.sv
// Result register that parts the scan logic from the result channel.
module sco_out (
    input  logic            clk,
    input  logic            rst_n,
    input  sco_pkg::push_t  push,
    output logic            out_free,
    sco_rsp_if.source       rsp
);
    import sco_pkg::*;

    logic out_valid_reg;
    rsp_t item_reg;

    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push.en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.en)
        begin
            item_reg <= push.item;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.span_valid  = item_reg.span_valid;
    assign rsp.span_start  = item_reg.span_start;
    assign rsp.span_end    = item_reg.span_end;
    assign rsp.any_open    = item_reg.any_open;
    assign rsp.last_result = item_reg.last_result;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push.en |-> out_free)
        else $error("result pushed into a full result register");
`endif

endmodule

FILE: sv/sco_ctrl.sv
// Row-by-row scan sequencer that reads, marks and writes back the occupancy rows.
module sco_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    sco_req_if.sink                          req,
    input  logic                             out_free,
    output sco_pkg::push_t                   push,
    output sco_pkg::mem_req_t                mem_req,
    input  logic [sco_pkg::WORD_BITS-1:0]    rd_data
);
    import sco_pkg::*;

    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic                 solid_reg, solid_next;
    logic [COL_W-1:0]     c_reg, c_next;
    logic [RANGE_W-1:0]   hi_reg, hi_next;
    logic                 run_reg, run_next;
    logic [COL_W-1:0]     run_start_reg, run_start_next;
    logic [WORD_BITS-1:0] mark_reg, mark_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [COL_W-1:0]     pend_start_reg, pend_start_next;
    logic [COL_W-1:0]     pend_end_reg, pend_end_next;
    logic                 any_reg, any_next;
    logic [ROWS-1:0]      row_valid_reg, row_valid_next;
    logic                 rd_valid_reg;

    logic [RANGE_W-1:0]    lo_clamp, hi_clamp;
    logic                  start_scan;
    logic                  scan_done;
    logic [ROW_W-1:0]      row;
    logic [WORD_BITS-1:0]  occ;
    logic [WORD_BITS-1:0]  in_range;
    logic [WORD_BITS-1:0]  open_bits, closed_bits;
    logic [WORD_IDX_W-1:0] j_open, j_closed;
    logic [RANGE_W-1:0]    row_end;
    logic                  ends_here;
    logic [WORD_BITS-1:0]  run_mask;
    logic [WORD_BITS-1:0]  new_mark;
    logic [COL_W-1:0]      span_end;
    logic                  emit;

    assign lo_clamp   = clamp_col(req.first_col);
    assign hi_clamp   = clamp_col(req.end_col);
    assign req.ready  = (state_reg == ST_IDLE);

    // Row under the cursor and its occupancy; a row never written since a clear reads open.
    assign row     = c_reg[COL_W-1:WORD_IDX_W];
    assign occ     = rd_valid_reg ? rd_data : '0;
    assign row_end = (RANGE_W'(row) + RANGE_W'(1)) << WORD_IDX_W;

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            in_range[j] = ({1'b0, row, WORD_IDX_W'(j)} >= {1'b0, c_reg})
                       && ({1'b0, row, WORD_IDX_W'(j)} < hi_reg);
        end
    end

    assign open_bits   = in_range & ~occ;
    assign closed_bits = in_range & occ;
    assign j_open      = first_one(open_bits);
    assign j_closed    = first_one(closed_bits);
    assign ends_here   = (hi_reg <= row_end);
    assign run_mask    = (|closed_bits) ? (in_range & below_mask(j_closed)) : in_range;
    assign new_mark    = mark_reg | ((run_reg && solid_reg) ? run_mask : '0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = start_scan ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        op_next         = op_reg;
        solid_next      = solid_reg;
        c_next          = c_reg;
        hi_next         = hi_reg;
        run_next        = run_reg;
        run_start_next  = run_start_reg;
        mark_next       = mark_reg;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        any_next        = any_reg;
        row_valid_next  = row_valid_reg;
        start_scan      = 1'b0;
        scan_done       = 1'b0;
        emit            = 1'b0;
        span_end        = '0;
        push            = '0;
        mem_req         = '0;
        mem_req.wr_addr = row;
        mem_req.wr_data = occ | new_mark;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.operation;
                    solid_next      = req.solid;
                    hi_next         = hi_clamp;
                    c_next          = lo_clamp[COL_W-1:0];
                    run_next        = 1'b0;
                    mark_next       = '0;
                    pend_valid_next = 1'b0;
                    any_next        = 1'b0;
                    case (req.operation)
                        OP_CLEAR:
                        begin
                            row_valid_next = '0;
                        end
                        OP_CLIP, OP_TEST:
                        begin
                            if (hi_clamp > lo_clamp)
                            begin
                                start_scan      = 1'b1;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = lo_clamp[COL_W-1:WORD_IDX_W];
                            end
                        end
                        default:
                        begin
                            start_scan = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    if (!run_reg)
                    begin
                        if (|open_bits)
                        begin
                            if (op_reg == OP_TEST)
                            begin
                                any_next  = 1'b1;
                                scan_done = 1'b1;
                            end
                            else
                            begin
                                run_next       = 1'b1;
                                run_start_next = {row, j_open};
                                c_next         = {row, j_open};
                            end
                        end
                        else if (ends_here)
                        begin
                            scan_done     = 1'b1;
                            mem_req.wr_en = |mark_reg;
                        end
                        else
                        begin
                            c_next          = row_end[COL_W-1:0];
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = row + ROW_W'(1);
                            mem_req.wr_en   = |mark_reg;
                            mark_next       = '0;
                        end
                    end
                    else
                    begin
                        if (|closed_bits)
                        begin
                            // The run stops just before the first occupied column.
                            emit      = 1'b1;
                            span_end  = {row, j_closed} - COL_W'(1);
                            run_next  = 1'b0;
                            c_next    = {row, j_closed};
                            mark_next = new_mark;
                        end
                        else if (ends_here)
                        begin
                            emit          = 1'b1;
                            span_end      = hi_reg[COL_W-1:0] - COL_W'(1);
                            scan_done     = 1'b1;
                            mem_req.wr_en = |new_mark;
                        end
                        else
                        begin
                            c_next          = row_end[COL_W-1:0];
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = row + ROW_W'(1);
                            mem_req.wr_en   = |new_mark;
                            mark_next       = '0;
                        end
                    end
                end
                // A finished run waits in the pending slot until we know whether another follows.
                if (emit)
                begin
                    push.en               = pend_valid_reg;
                    push.item.span_valid  = 1'b1;
                    push.item.span_start  = pend_start_reg;
                    push.item.span_end    = pend_end_reg;
                    pend_valid_next       = 1'b1;
                    pend_start_next       = run_start_reg;
                    pend_end_next         = span_end;
                end
                if (mem_req.wr_en)
                begin
                    row_valid_next[row] = 1'b1;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    push.en               = 1'b1;
                    push.item.span_valid  = pend_valid_reg;
                    push.item.span_start  = pend_valid_reg ? pend_start_reg : '0;
                    push.item.span_end    = pend_valid_reg ? pend_end_reg : '0;
                    push.item.any_open    = any_reg;
                    push.item.last_result = 1'b1;
                end
            end
            default:
            begin
                push = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            run_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            any_reg        <= 1'b0;
            row_valid_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            mark_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            run_reg        <= run_next;
            pend_valid_reg <= pend_valid_next;
            any_reg        <= any_next;
            row_valid_reg  <= row_valid_next;
            mark_reg       <= mark_next;
            if (mem_req.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[mem_req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        solid_reg      <= solid_next;
        c_reg          <= c_next;
        hi_reg         <= hi_next;
        run_start_reg  <= run_start_next;
        pend_start_reg <= pend_start_next;
        pend_end_reg   <= pend_end_next;
    end

`ifndef SYNTHESIS
    a_run_only_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && run_reg) |-> (op_reg == OP_CLIP))
        else $error("open run tracked outside a clip operation");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ({1'b0, c_reg} < hi_reg))
        else $error("scan cursor reached the end of the range");

    a_no_same_row_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
        else $error("row read and written back in the same cycle");

    a_final_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (push.en && push.item.last_result) |=> (state_reg == ST_IDLE))
        else $error("final result pushed without returning to idle");
`endif

endmodule

FILE: verif/solid_column_occlusion_tb.sv
// Self-checking testbench for the solid column occlusion map with its own span predictor.
module solid_column_occlusion_tb;
    import sco_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 200;

    logic clk;
    logic rst_n;

    sco_req_if req_ch ();
    sco_rsp_if rsp_ch ();

    solid_column_occlusion dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted map: one bit per column, set when the column is occupied.
    logic [COLUMNS-1:0] column_taken;
    rsp_t expected_spans[$];

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $realtime,
                     expected_spans.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int saturate_col(input logic [RANGE_W-1:0] v);
        return (int'(v) > COLUMNS) ? COLUMNS : int'(v);
    endfunction

    function automatic rsp_t make_span(input logic valid, input int start_col,
                                       input int end_col, input logic open);
        rsp_t r;
        r.span_valid  = valid;
        r.span_start  = COL_W'(start_col);
        r.span_end    = COL_W'(end_col);
        r.any_open    = open;
        r.last_result = 1'b0;
        return r;
    endfunction

    // Works out the results of one accepted request and updates the predicted map.
    function automatic void predict_spans(input logic [OP_W-1:0] op,
                                          input logic [RANGE_W-1:0] first,
                                          input logic [RANGE_W-1:0] stop,
                                          input logic solid);
        int lo;
        int hi;
        int c;
        int run_start;
        logic open;
        rsp_t batch[$];
        lo = saturate_col(first);
        hi = saturate_col(stop);
        if (op == OP_CLEAR)
        begin
            column_taken = '0;
            batch.push_back(make_span(1'b0, 0, 0, 1'b0));
        end
        else if (op == OP_TEST)
        begin
            open = 1'b0;
            for (c = lo; c < hi; c++)
            begin
                if (!column_taken[c])
                begin
                    open = 1'b1;
                end
            end
            batch.push_back(make_span(1'b0, 0, 0, open));
        end
        else if (op == OP_CLIP)
        begin
            c = lo;
            while (c < hi)
            begin
                if (column_taken[c])
                begin
                    c++;
                end
                else
                begin
                    run_start = c;
                    while (c < hi)
                    begin
                        if (column_taken[c])
                        begin
                            break;
                        end
                        c++;
                    end
                    batch.push_back(make_span(1'b1, run_start, c - 1, 1'b0));
                    if (solid)
                    begin
                        for (int k = run_start; k < c; k++)
                        begin
                            column_taken[k] = 1'b1;
                        end
                    end
                end
            end
            if (batch.size() == 0)
            begin
                batch.push_back(make_span(1'b0, 0, 0, 1'b0));
            end
        end
        else
        begin
            batch.push_back(make_span(1'b0, 0, 0, 1'b0));
        end
        batch[batch.size() - 1].last_result = 1'b1;
        foreach (batch[i])
        begin
            expected_spans.push_back(batch[i]);
        end
    endfunction

    function automatic void check_span();
        rsp_t got;
        rsp_t want;
        got.span_valid  = rsp_ch.span_valid;
        got.span_start  = rsp_ch.span_start;
        got.span_end    = rsp_ch.span_end;
        got.any_open    = rsp_ch.any_open;
        got.last_result = rsp_ch.last_result;
        if (expected_spans.size() == 0)
        begin
            error_count++;
            $display("%0t: unexpected result valid=%0d start=%0d end=%0d open=%0d last=%0d",
                     $realtime, got.span_valid, got.span_start, got.span_end,
                     got.any_open, got.last_result);
            return;
        end
        want = expected_spans.pop_front();
        if (got !== want)
        begin
            error_count++;
            $display("%0t: mismatch expected valid=%0d start=%0d end=%0d open=%0d last=%0d",
                     $realtime, want.span_valid, want.span_start, want.span_end,
                     want.any_open, want.last_result);
            $display("%0t:          actual   valid=%0d start=%0d end=%0d open=%0d last=%0d",
                     $realtime, got.span_valid, got.span_start, got.span_end,
                     got.any_open, got.last_result);
        end
    endfunction

    // Result side: checks each beat and drives ready, with an optional long hold-off.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                check_span();
            end
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Valid is left high after a beat; it drops when an idle gap is taken or when the bench waits for the drain.
    task automatic send_request(input logic [OP_W-1:0] op, input int first,
                                input int stop, input logic solid);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.first_col <= RANGE_W'(first);
        req_ch.end_col   <= RANGE_W'(stop);
        req_ch.solid     <= solid;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        predict_spans(op, RANGE_W'(first), RANGE_W'(stop), solid);
    endtask

    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        while (expected_spans.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic int random_col();
        if ($urandom_range(99) < 85)
        begin
            return $urandom_range(0, COLUMNS);
        end
        return $urandom_range(0, 255);
    endfunction

    task automatic send_random_request();
        int pick;
        int first;
        int stop;
        logic [OP_W-1:0] op;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            op = OP_CLIP;
        end
        else if (pick < 88)
        begin
            op = OP_TEST;
        end
        else if (pick < 94)
        begin
            op = OP_CLEAR;
        end
        else
        begin
            op = OP_UNUSED;
        end
        first = random_col();
        // Mostly short ranges so the map breaks up into many runs.
        if ($urandom_range(99) < 65)
        begin
            stop = first + $urandom_range(0, 24);
            if (stop > 255)
            begin
                stop = 255;
            end
        end
        else
        begin
            stop = random_col();
        end
        send_request(op, first, stop, 1'($urandom_range(0, 1)));
    endtask

    task automatic test_directed();
        send_request(OP_CLIP, 0, 128, 1'b0);
        send_request(OP_TEST, 0, 128, 1'b0);
        send_request(OP_CLIP, 10, 20, 1'b1);
        send_request(OP_CLIP, 0, 128, 1'b0);
        send_request(OP_TEST, 10, 20, 1'b0);
        send_request(OP_TEST, 9, 21, 1'b1);
        send_request(OP_CLIP, 12, 15, 1'b1);
        send_request(OP_CLIP, 50, 50, 1'b1);
        send_request(OP_CLIP, 90, 40, 1'b1);
        send_request(OP_TEST, 60, 60, 1'b0);
        send_request(OP_CLIP, 120, 255, 1'b1);
        send_request(OP_CLIP, 255, 255, 1'b1);
        send_request(OP_CLIP, 128, 200, 1'b0);
        send_request(OP_TEST, 0, 255, 1'b0);
        send_request(OP_UNUSED, 255, 255, 1'b1);
        send_request(OP_CLEAR, 255, 255, 1'b1);
        send_request(OP_TEST, 10, 20, 1'b0);
        send_request(OP_CLIP, 0, 1, 1'b1);
        send_request(OP_CLIP, 127, 128, 1'b1);
        send_request(OP_CLIP, 0, 128, 1'b1);
        send_request(OP_TEST, 0, 128, 1'b0);
        send_request(OP_CLIP, 0, 128, 1'b0);
        send_request(OP_CLEAR, 0, 0, 1'b0);
        wait_for_drain();
    endtask

    task automatic test_random_phase(input int count, input int idle_pct,
                                     input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            send_random_request();
        end
        wait_for_drain();
    endtask

    // Every other column occupied: a full-width clip then yields the most runs.
    task automatic test_checkerboard();
        send_request(OP_CLEAR, 0, 0, 1'b0);
        for (int c = 0; c < COLUMNS; c += 2)
        begin
            send_request(OP_CLIP, c, c + 1, 1'b1);
        end
        send_request(OP_CLIP, 0, 128, 1'b0);
        send_request(OP_TEST, 0, 128, 1'b0);
        send_request(OP_CLIP, 0, 128, 1'b1);
        send_request(OP_TEST, 0, 128, 1'b0);
        send_request(OP_CLIP, 0, 128, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_request(OP_CLEAR, 0, 0, 1'b0);
        hold_request = 400;
        repeat (10)
        begin
            send_random_request();
        end
        wait_for_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        column_taken = '0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_CLEAR;
        req_ch.first_col <= '0;
        req_ch.end_col   <= '0;
        req_ch.solid     <= 1'b0;
        repeat (10)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(17, 0, 0);
        test_random_phase(17, 80, 0);
        test_random_phase(17, 0, 80);
        send_idle_pct = 33;
        recv_stall_pct = 33;
        test_checkerboard();
        test_random_phase(17, 33, 33);
        test_backpressure();

        wait_for_drain();
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
        if (error_count == 0 && expected_spans.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
